// File: src/ppch_pkg.sv
// ----------------------------------------------------------------------------
// Plane-projected compass heading: shared package
// Widths, register codes, the arctangent table and the structs that pass
// between the pipeline sections.
// ----------------------------------------------------------------------------
package ppch_pkg;

  // Field widths fixed by the interface.
  localparam int MAG_W  = 16;   // magnetometer sample
  localparam int AXIS_W = 18;   // side and north vector components
  localparam int OFF_W  = 41;   // side and north offsets
  localparam int HDG_W  = 16;   // heading in hundredths of a degree
  localparam int CFG_W  = OFF_W;
  localparam int CFG_IDX_W = 3;

  // One axis product, and the projected coordinates with room for the
  // CORDIC gain of about 1.65 on top of the largest projected magnitude.
  localparam int PROD_W = AXIS_W + MAG_W;
  localparam int CW     = 44;

  // Binary angle: 2^32 is a full turn.
  localparam int ANG_W  = 32;
  localparam logic [ANG_W-1:0] ANG_HALF = 32'h8000_0000;

  // Iteration count, limited to the size of the arctangent table.
  localparam int CORDIC_STEPS = 20;
  localparam int NSTEP = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  // Scaling of the binary angle to hundredths of a degree.
  localparam int PROD_SC_W = ANG_W + HDG_W;
  localparam logic [HDG_W-1:0] HDG_SCALE = 16'd36000;
  localparam logic [HDG_W-1:0] HDG_WRAP  = 16'd35999;

  // atan(2^-i) in units of 2^-32 turns.
  localparam logic [ANG_W-1:0] ATAN_TURNS [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDE_X       = 3'd0,
    REG_SIDE_Y       = 3'd1,
    REG_SIDE_Z       = 3'd2,
    REG_NORTH_X      = 3'd3,
    REG_NORTH_Y      = 3'd4,
    REG_NORTH_Z      = 3'd5,
    REG_SIDE_OFFSET  = 3'd6,
    REG_NORTH_OFFSET = 3'd7
  } ppch_reg_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] side_x;
    logic signed [AXIS_W-1:0] side_y;
    logic signed [AXIS_W-1:0] side_z;
    logic signed [AXIS_W-1:0] north_x;
    logic signed [AXIS_W-1:0] north_y;
    logic signed [AXIS_W-1:0] north_z;
    logic signed [OFF_W-1:0]  side_offset;
    logic signed [OFF_W-1:0]  north_offset;
  } ppch_cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [MAG_W-1:0] mag_x;
    logic signed [MAG_W-1:0] mag_y;
    logic signed [MAG_W-1:0] mag_z;
  } ppch_mag_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] c;
  } ppch_sc_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [ANG_W-1:0] angle;
  } ppch_ang_t;

  typedef struct packed {
    logic             valid;
    logic [HDG_W-1:0] heading;
  } ppch_hdg_t;

endpackage

// File: src/ppch_if.sv
// ----------------------------------------------------------------------------
// Plane-projected compass heading: channel interfaces
// Valid/ready channels for magnetometer samples and for headings.
// ----------------------------------------------------------------------------
interface ppch_in_if;
  import ppch_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [MAG_W-1:0] mag_x;
  logic signed [MAG_W-1:0] mag_y;
  logic signed [MAG_W-1:0] mag_z;

  modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
  modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

interface ppch_out_if;
  import ppch_pkg::*;

  logic             valid;
  logic             ready;
  logic [HDG_W-1:0] heading_centideg;

  modport source (output valid, output heading_centideg, input ready);
  modport sink   (input valid, input heading_centideg, output ready);
endinterface

// File: src/plane_projected_compass_heading_top.sv
// ----------------------------------------------------------------------------
// Plane-projected compass heading: top level
// Turns one 3-axis magnetometer sample into a heading in hundredths of a
// degree, measured in the calibrated plane from the calibrated north.
// ----------------------------------------------------------------------------
// The block accepts one magnetometer item on every clock cycle on which
// in_ch.ready is high and returns one heading item for each, in order. An
// accepted sample passes through the projection stages, the half-turn
// pre-rotation stage, a stage for each CORDIC iteration, the scaling stages
// and the output register on its way to the output. The iteration count
// sets the pipeline depth but not the rate. When the consumer holds ready
// low, the output register and a spare entry absorb one item each before
// the whole pipeline, and with it in_ch.ready, freezes; nothing is lost or
// repeated. The heading is atan2(side.s - side_offset, north.s - north_offset)
// in the range 0 to 35998; a zero vector and anything at or above 359.99
// degrees give 0. The calibration registers are written through the cfg_
// port and should only change while no item is in flight. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module plane_projected_compass_heading_top (
  input  logic                         clk,
  input  logic                         rst_n,
  ppch_in_if.sink                      in_ch,
  ppch_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [ppch_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ppch_pkg::CFG_W-1:0]   cfg_wdata
);
  import ppch_pkg::*;

  ppch_cfg_t cfg_r;
  ppch_mag_t mag;
  ppch_sc_t  sc;
  ppch_ang_t ang;
  ppch_hdg_t hdg;
  logic      en;

  // Calibration registers. The index decodes onto all eight registers; the
  // upper bits of the data are dropped for the narrower vector components.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (ppch_reg_t'(cfg_idx))
        REG_SIDE_X:       cfg_r.side_x       <= cfg_wdata[AXIS_W-1:0];
        REG_SIDE_Y:       cfg_r.side_y       <= cfg_wdata[AXIS_W-1:0];
        REG_SIDE_Z:       cfg_r.side_z       <= cfg_wdata[AXIS_W-1:0];
        REG_NORTH_X:      cfg_r.north_x      <= cfg_wdata[AXIS_W-1:0];
        REG_NORTH_Y:      cfg_r.north_y      <= cfg_wdata[AXIS_W-1:0];
        REG_NORTH_Z:      cfg_r.north_z      <= cfg_wdata[AXIS_W-1:0];
        REG_SIDE_OFFSET:  cfg_r.side_offset  <= cfg_wdata[OFF_W-1:0];
        REG_NORTH_OFFSET: cfg_r.north_offset <= cfg_wdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Every pipeline stage advances together whenever the skid buffer has
  // room, so the input is ready on exactly those cycles.
  assign in_ch.ready = en;

  assign mag.valid = in_ch.valid;
  assign mag.mag_x = in_ch.mag_x;
  assign mag.mag_y = in_ch.mag_y;
  assign mag.mag_z = in_ch.mag_z;

  ppch_proj u_proj (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .mag_i (mag),
    .sc_o  (sc)
  );

  ppch_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .sc_i  (sc),
    .ang_o (ang)
  );

  ppch_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ang_i (ang),
    .hdg_o (hdg)
  );

  ppch_skid u_skid (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_i        (hdg),
    .up_ready    (en),
    .out_valid   (out_ch.valid),
    .out_heading (out_ch.heading_centideg),
    .out_ready   (out_ch.ready)
  );

endmodule

// File: src/ppch_proj.sv
// ----------------------------------------------------------------------------
// Plane projection
// Two stages: the six axis products, then the two dot products less their
// offsets, giving the sine term S and the cosine term C.
// ----------------------------------------------------------------------------
module ppch_proj (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ppch_pkg::ppch_cfg_t cfg,
  input  ppch_pkg::ppch_mag_t mag_i,
  output ppch_pkg::ppch_sc_t  sc_o
);
  import ppch_pkg::*;

  logic                     vld1_r;
  logic signed [PROD_W-1:0] sx_r, sy_r, sz_r, nx_r, ny_r, nz_r;
  logic                     vld2_r;
  logic signed [CW-1:0]     s_r, c_r;
  logic signed [CW-1:0]     s_nxt, c_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= mag_i.valid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= PROD_W'(cfg.side_x)  * PROD_W'(mag_i.mag_x);
      sy_r <= PROD_W'(cfg.side_y)  * PROD_W'(mag_i.mag_y);
      sz_r <= PROD_W'(cfg.side_z)  * PROD_W'(mag_i.mag_z);
      nx_r <= PROD_W'(cfg.north_x) * PROD_W'(mag_i.mag_x);
      ny_r <= PROD_W'(cfg.north_y) * PROD_W'(mag_i.mag_y);
      nz_r <= PROD_W'(cfg.north_z) * PROD_W'(mag_i.mag_z);
      s_r  <= s_nxt;
      c_r  <= c_nxt;
    end
  end

  assign s_nxt = CW'(sx_r) + CW'(sy_r) + CW'(sz_r) - CW'(cfg.side_offset);
  assign c_nxt = CW'(nx_r) + CW'(ny_r) + CW'(nz_r) - CW'(cfg.north_offset);

  assign sc_o.valid = vld2_r;
  assign sc_o.s     = s_r;
  assign sc_o.c     = c_r;

endmodule

// File: src/ppch_cordic.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// A half-turn pre-rotation stage brings C to the right half plane, then one
// registered stage per iteration drives S towards zero and builds the angle.
// ----------------------------------------------------------------------------
module ppch_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ppch_pkg::ppch_sc_t  sc_i,
  output ppch_pkg::ppch_ang_t ang_o
);
  import ppch_pkg::*;

  logic                 vld_r  [0:NSTEP];
  logic                 zero_r [0:NSTEP];
  logic signed [CW-1:0] s_r    [0:NSTEP];
  logic signed [CW-1:0] c_r    [0:NSTEP];
  logic [ANG_W-1:0]     ang_r  [0:NSTEP];

  logic                 zero_nxt;
  logic                 flip;
  logic signed [CW-1:0] s0_nxt, c0_nxt;
  logic [ANG_W-1:0]     ang0_nxt;

  // A zero vector is flagged here and forced to a heading of zero at the end.
  assign zero_nxt = (sc_i.s == '0) && (sc_i.c == '0);
  assign flip     = sc_i.c[CW-1];
  assign s0_nxt   = flip ? -sc_i.s : sc_i.s;
  assign c0_nxt   = flip ? -sc_i.c : sc_i.c;
  assign ang0_nxt = flip ? ANG_HALF : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= sc_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= zero_nxt;
      s_r[0]    <= s0_nxt;
      c_r[0]    <= c0_nxt;
      ang_r[0]  <= ang0_nxt;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_iter
    logic signed [CW-1:0] ds;
    logic signed [CW-1:0] dc;
    logic                 up;

    // Arithmetic shifts round towards minus infinity.
    assign ds = s_r[i] >>> i;
    assign dc = c_r[i] >>> i;
    assign up = ~s_r[i][CW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (up) begin
          c_r[i+1]   <= c_r[i] + ds;
          s_r[i+1]   <= s_r[i] - dc;
          ang_r[i+1] <= ang_r[i] + ATAN_TURNS[i];
        end else begin
          c_r[i+1]   <= c_r[i] - ds;
          s_r[i+1]   <= s_r[i] + dc;
          ang_r[i+1] <= ang_r[i] - ATAN_TURNS[i];
        end
      end
    end
  end

  assign ang_o.valid = vld_r[NSTEP];
  assign ang_o.zero  = zero_r[NSTEP];
  assign ang_o.angle = ang_r[NSTEP];

endmodule

// File: src/ppch_scale.sv
// ----------------------------------------------------------------------------
// Heading scaling
// Multiplies the binary angle by 36000 and keeps the upper bits, then
// folds the zero vector and the near-full-circle case to zero.
// ----------------------------------------------------------------------------
module ppch_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ppch_pkg::ppch_ang_t ang_i,
  output ppch_pkg::ppch_hdg_t hdg_o
);
  import ppch_pkg::*;

  logic [PROD_SC_W-1:0] prod;
  logic                 vld1_r;
  logic                 zero1_r;
  logic [HDG_W-1:0]     raw_r;
  logic                 vld2_r;
  logic [HDG_W-1:0]     hdg_r;
  logic [HDG_W-1:0]     hdg_nxt;

  assign prod    = PROD_SC_W'(ang_i.angle) * PROD_SC_W'(HDG_SCALE);
  assign hdg_nxt = (zero1_r || (raw_r >= HDG_WRAP)) ? '0 : raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= ang_i.valid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero1_r <= ang_i.zero;
      raw_r   <= prod[PROD_SC_W-1:ANG_W];
      hdg_r   <= hdg_nxt;
    end
  end

  assign hdg_o.valid   = vld2_r;
  assign hdg_o.heading = hdg_r;

endmodule

// File: src/ppch_skid.sv
// ----------------------------------------------------------------------------
// Output skid buffer
// Output register plus one spare entry, so that the pipeline's stall
// signal comes straight from a flip-flop.
// ----------------------------------------------------------------------------
module ppch_skid (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ppch_pkg::ppch_hdg_t     up_i,
  output logic                    up_ready,
  output logic                    out_valid,
  output logic [ppch_pkg::HDG_W-1:0] out_heading,
  input  logic                    out_ready
);
  import ppch_pkg::*;

  logic             out_valid_r;
  logic [HDG_W-1:0] out_hdg_r;
  logic             sp_valid_r;
  logic [HDG_W-1:0] sp_hdg_r;
  logic             up_fire;

  assign up_ready = ~sp_valid_r;
  assign up_fire  = up_i.valid & up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sp_valid_r  <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (sp_valid_r) begin
        out_valid_r <= 1'b1;
        out_hdg_r   <= sp_hdg_r;
        sp_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= up_fire;
        out_hdg_r   <= up_i.heading;
      end
    end else if (up_fire) begin
      sp_valid_r <= 1'b1;
      sp_hdg_r   <= up_i.heading;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_heading = out_hdg_r;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Plane-projected compass heading: testbench
// Drives magnetometer samples through the heading block with a range of
// calibrations. A predictor computes the heading of every accepted item.
// A checker compares each heading that leaves the block, in order, with
// the prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppch_pkg::*;

  // Number of registers between an accepted sample and its heading.
  localparam int LATENCY = NSTEP + 6;
  // Length of the deliberate output hold-off in the back-pressure test.
  localparam int HOLD_CYCLES = 400;
  // Far above the slowest correct run.
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  // Longest idle gap the sender inserts before one item.
  localparam int MAX_GAP = 40;

  localparam int AXIS_MAX = 131071;
  localparam int AXIS_MIN = -131072;
  localparam longint OFF_MAX = 64'sd1099511627775;
  localparam longint OFF_MIN = -64'sd1099511627776;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum int {
    CAL_REALISTIC,
    CAL_FULL,
    CAL_EXTREME,
    CAL_TINY
  } cal_style_t;

  // One predicted heading, tagged with the number of the sample it belongs to.
  typedef struct {
    int unsigned      seq;
    logic [HDG_W-1:0] heading;
  } heading_exp_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  ppch_in_if  in_ch ();
  ppch_out_if out_ch ();

  plane_projected_compass_heading_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // The testbench's own copy of the calibration registers.
  ppch_cfg_t cal;

  // Headings predicted for accepted samples, oldest first.
  heading_exp_t heading_q[$];

  int unsigned     sent_count;
  int unsigned     error_count = 0;
  longint unsigned cycle_count = 0;

  // Idling percentages for the sender and the receiver, set per phase.
  int src_idle_pct;
  int snk_stall_pct;
  // Each increment asks the ready driver for one long hold-off.
  int hold_seq;

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // The projected coordinates are exact integers of at most 42 bits, and the
  // CORDIC gain adds less than one more bit, so 64-bit arithmetic holds them
  // without loss. The arithmetic right shift rounds towards minus infinity,
  // which is the rounding the block uses.
  function automatic logic [HDG_W-1:0] calc_heading(logic signed [MAG_W-1:0] mx,
                                                   logic signed [MAG_W-1:0] my,
                                                   logic signed [MAG_W-1:0] mz);
    longint           s;
    longint           c;
    longint           ds;
    longint           dc;
    logic [ANG_W-1:0] ang;
    logic [63:0]      scaled;
    s = longint'($signed(cal.side_x)) * longint'(mx)
      + longint'($signed(cal.side_y)) * longint'(my)
      + longint'($signed(cal.side_z)) * longint'(mz)
      - longint'($signed(cal.side_offset));
    c = longint'($signed(cal.north_x)) * longint'(mx)
      + longint'($signed(cal.north_y)) * longint'(my)
      + longint'($signed(cal.north_z)) * longint'(mz)
      - longint'($signed(cal.north_offset));
    // A vector of zero length has no direction; the block reports north.
    if (s == 0 && c == 0) begin
      return '0;
    end
    ang = '0;
    // Vectors in the left half-plane are turned through half a turn first,
    // so that the iterations only ever have to cover plus or minus 90 degrees.
    if (c < 0) begin
      c = -c;
      s = -s;
      ang = ANG_HALF;
    end
    for (int i = 0; i < NSTEP; i++) begin
      ds = s >>> i;
      dc = c >>> i;
      if (s >= 0) begin
        c = c + ds;
        s = s - dc;
        ang = ang + ATAN_TURNS[i];
      end else begin
        c = c - ds;
        s = s + dc;
        ang = ang - ATAN_TURNS[i];
      end
    end
    // The binary angle wraps by itself, so a negative angle is already in
    // range. Scaling to hundredths of a degree truncates.
    scaled = {32'd0, ang} * 64'(HDG_SCALE);
    // Anything at or above 359.99 degrees is reported as north.
    if (scaled[63:32] >= 64'(HDG_WRAP)) begin
      return '0;
    end
    return scaled[32 +: HDG_W];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  // The write enable is raised at a falling edge and stays high across
  // back-to-back writes; end_cfg lowers it once the series is complete.
  task automatic write_reg(ppch_reg_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    // Only the low bits of each register width count.
    case (idx)
      REG_SIDE_X:       cal.side_x       = data[AXIS_W-1:0];
      REG_SIDE_Y:       cal.side_y       = data[AXIS_W-1:0];
      REG_SIDE_Z:       cal.side_z       = data[AXIS_W-1:0];
      REG_NORTH_X:      cal.north_x      = data[AXIS_W-1:0];
      REG_NORTH_Y:      cal.north_y      = data[AXIS_W-1:0];
      REG_NORTH_Z:      cal.north_z      = data[AXIS_W-1:0];
      REG_SIDE_OFFSET:  cal.side_offset  = data[OFF_W-1:0];
      REG_NORTH_OFFSET: cal.north_offset = data[OFF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // An axis component with random junk in the bits above its width, which
  // the block has to ignore.
  function automatic logic [CFG_W-1:0] axis_word(int v);
    logic [CFG_W-1:0] w;
    w = CFG_W'({$urandom, $urandom});
    w[AXIS_W-1:0] = v[AXIS_W-1:0];
    return w;
  endfunction

  task automatic write_calibration(int sx, int sy, int sz, int nx, int ny, int nz,
                                   longint so, longint no);
    write_reg(REG_SIDE_X, axis_word(sx));
    write_reg(REG_SIDE_Y, axis_word(sy));
    write_reg(REG_SIDE_Z, axis_word(sz));
    write_reg(REG_NORTH_X, axis_word(nx));
    write_reg(REG_NORTH_Y, axis_word(ny));
    write_reg(REG_NORTH_Z, axis_word(nz));
    write_reg(REG_SIDE_OFFSET, so[CFG_W-1:0]);
    write_reg(REG_NORTH_OFFSET, no[CFG_W-1:0]);
    end_cfg();
  endtask

  function automatic int pick_axis_extreme();
    case ($urandom_range(4))
      0:       return AXIS_MIN;
      1:       return AXIS_MAX;
      2:       return 0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  function automatic longint pick_offset_extreme();
    case ($urandom_range(2))
      0:       return OFF_MIN;
      1:       return OFF_MAX;
      default: return 0;
    endcase
  endfunction

  // Draws a fresh calibration in one of several styles. The realistic style
  // derives its offsets from a plausible origin; the tiny style keeps the
  // projected vector short so that zero vectors turn up often.
  task automatic randomise_calibration();
    cal_style_t style;
    int         ax[6];
    int         org[3];
    longint     so;
    longint     no;
    style = cal_style_t'($urandom_range(3));
    case (style)
      CAL_REALISTIC: begin
        foreach (ax[i]) ax[i] = $urandom_range(8192) - 4096;
        foreach (org[i]) org[i] = $urandom_range(4000) - 2000;
        so = longint'(ax[0]) * org[0] + longint'(ax[1]) * org[1] + longint'(ax[2]) * org[2];
        no = longint'(ax[3]) * org[0] + longint'(ax[4]) * org[1] + longint'(ax[5]) * org[2];
      end
      CAL_FULL: begin
        foreach (ax[i]) ax[i] = $urandom;
        so = longint'({$urandom, $urandom});
        no = longint'({$urandom, $urandom});
      end
      CAL_EXTREME: begin
        foreach (ax[i]) ax[i] = pick_axis_extreme();
        so = pick_offset_extreme();
        no = pick_offset_extreme();
      end
      default: begin
        foreach (ax[i]) ax[i] = $urandom_range(6) - 3;
        so = int'($urandom_range(80)) - 40;
        no = int'($urandom_range(80)) - 40;
      end
    endcase
    write_calibration(ax[0], ax[1], ax[2], ax[3], ax[4], ax[5], so, no);
  endtask

  // --------------------------------------------------------------------------
  // Sample channel
  // --------------------------------------------------------------------------
  // Offers one item, after a random idle gap if the sender is meant to idle,
  // and returns at the rising edge at which the block accepts it. The
  // prediction is made against the calibration in force, which never
  // changes while items are in flight.
  task automatic send_sample(int mx, int my, int mz);
    int           gap;
    heading_exp_t item;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mag_x <= mx[MAG_W-1:0];
    in_ch.mag_y <= my[MAG_W-1:0];
    in_ch.mag_z <= mz[MAG_W-1:0];
    item.seq = sent_count;
    item.heading = calc_heading(mx[MAG_W-1:0], my[MAG_W-1:0], mz[MAG_W-1:0]);
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    heading_q.push_back(item);
    sent_count++;
  endtask

  function automatic int pick_mag_extreme();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  // Mostly full-range samples, with a share of extremes and of very short
  // vectors that, against a tiny calibration, give zero or near-zero
  // projections.
  task automatic send_random_sample();
    int mv[3];
    int pick;
    pick = $urandom_range(9);
    foreach (mv[i]) begin
      if (pick < 6) begin
        mv[i] = $urandom;
      end else if (pick < 8) begin
        mv[i] = pick_mag_extreme();
      end else begin
        mv[i] = $urandom_range(8) - 4;
      end
    end
    send_sample(mv[0], mv[1], mv[2]);
  endtask

  // Lowers valid and waits until every predicted heading has come back, so
  // that the pipeline is empty and the registers may be rewritten.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 59; snk_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  snk_stall_pct = 59; end
      default:       begin src_idle_pct = 20; snk_stall_pct = 20; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Heading channel
  // --------------------------------------------------------------------------
  // Ready changes at the falling edge. A request for a long hold-off is
  // noticed by its sequence number and counted down here, in cycles, while
  // the sender carries on offering items.
  always @(negedge clk) begin : drive_ready
    static int hold_seen = 0;
    static int hold_left = 0;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Every accepted heading is matched against the oldest prediction.
  always @(posedge clk) begin : check_headings
    heading_exp_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (heading_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected heading %0d with no sample outstanding",
                   out_ch.heading_centideg);
        end
      end else begin
        want = heading_q.pop_front();
        if (out_ch.heading_centideg !== want.heading) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("heading mismatch on sample %0d: expected %0d, got %0d",
                     want.seq, want.heading, out_ch.heading_centideg);
          end
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // With every register at its reset value of zero, each projection is the
  // zero vector and the heading must be north.
  task automatic test_reset_state();
    set_idle(IDLE_NONE);
    send_sample(0, 0, 0);
    send_sample(32767, -32768, 5);
    drain();
  endtask

  // North along x and side along y: the four cardinal points, among them a
  // vector exactly behind north, two in the third quadrant, a direction a hair
  // below a full turn which must fold to north, and a sample that only has
  // the z component the calibration ignores.
  task automatic test_cardinal_points();
    write_calibration(0, 1000, 0, 1000, 0, 0, 0, 0);
    send_sample(100, 0, 0);
    send_sample(0, 100, 0);
    send_sample(-100, 0, 0);
    send_sample(0, -100, 0);
    send_sample(-100, -100, 0);
    send_sample(32767, -1, 0);
    send_sample(0, 0, 32767);
    send_sample(-32768, -32768, -32768);
    drain();
  endtask

  // Non-zero offsets: a sample sitting on the origin gives a zero vector,
  // and the others check that the offsets are subtracted with the right sign.
  task automatic test_offset_removal();
    write_calibration(1, 0, 0, 0, 0, 1, 5, -7);
    send_sample(5, 9, -7);
    send_sample(5, 0, 100);
    send_sample(6, 0, -7);
    send_sample(4, -3, -8);
    send_sample(-32768, 0, 32767);
    send_sample(32767, 0, -32768);
    drain();
  endtask

  // Registers at their limits, with samples at theirs, to reach the widest
  // projected coordinates the block has to carry.
  task automatic test_register_extremes();
    write_calibration(AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN,
                      OFF_MAX, OFF_MIN);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, -32768, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(0, 0, 0);
    drain();
    write_calibration(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MIN, AXIS_MIN,
                      OFF_MIN, OFF_MAX);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    drain();
  endtask

  // Random samples under one idling pattern; the calibration is redrawn
  // every sixty items, once the pipeline has emptied.
  task automatic test_random(idle_mode_t mode, int n_items);
    set_idle(mode);
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        drain();
        randomise_calibration();
      end
      send_random_sample();
    end
    drain();
  endtask

  // The receiver holds off for a long stretch while the sender streams
  // without a gap, so the output register, the spare entry and the whole
  // pipeline fill and the block must stall its input without losing or
  // repeating an item.
  task automatic test_full_pipeline_stall();
    set_idle(IDLE_NONE);
    randomise_calibration();
    hold_seq++;
    for (int k = 0; k < 80; k++) send_random_sample();
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.mag_x  = '0;
    in_ch.mag_y  = '0;
    in_ch.mag_z  = '0;
    cal          = '0;
    sent_count   = 0;
    hold_seq     = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;

    // Synchronous reset, held from time zero and released at a falling edge.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_cardinal_points();
    test_offset_removal();
    test_register_extremes();
    test_random(IDLE_NONE, 180);
    test_random(IDLE_SENDER, 180);
    test_random(IDLE_RECEIVER, 180);
    test_full_pipeline_stall();
    test_random(IDLE_BOTH, 180);

    // Everything has been accepted and answered; the checker then catches any
    // stray heading that the block still puts out before the end.
    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (error_count == 0 && heading_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ppch_pkg.sv
src/ppch_if.sv
src/ppch_proj.sv
src/ppch_cordic.sv
src/ppch_scale.sv
src/ppch_skid.sv
src/plane_projected_compass_heading_top.sv
tb/sv/tb.sv
